// ----- sv/ampa_mks_pkg.sv -----
// Shared types, constants and the step table for the AMPA kinetic step block.
`timescale 1ns / 1ps

package ampa_mks_pkg;

    localparam int FRAC_W  = 16;   // Q1.15 state fraction
    localparam int KB_W    = 24;   // effective binding rate, Q.15
    localparam int OPA_W   = 25;   // multiplier rate-side operand, signed
    localparam int OPB_W   = 28;   // multiplier fraction-side operand, signed
    localparam int ACC_W   = 48;   // accumulator, Q.30
    localparam int WORK_W  = 30;   // unclamped fractions during a step
    localparam int DIFF_W  = 17;   // voltage minus reversal potential
    localparam int SUM_W   = 18;   // sum of five clamped fractions
    localparam int CUR_W   = 32;
    localparam int STEP_W  = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [FRAC_W-1:0]        ONE_Q15    = 16'h8000;
    localparam logic signed [WORK_W-1:0] ONE_WORK   = 30'sd32768;
    localparam logic [SUM_W-1:0]         ONE_SUM    = 18'd32768;
    localparam logic signed [ACC_W-1:0]  HALF_Q15   = 48'sd16384;
    localparam logic signed [ACC_W-1:0]  HALF_Q8    = 48'sd128;
    localparam logic signed [ACC_W-1:0]  CUR_MAX    = 48'sh0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0]  CUR_MIN    = 48'shFFFF_8000_0000;
    localparam logic [STEP_W-1:0]        LAST_STEP  = 5'd24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_RATE   = 3'd0,
        REG_CLOSE_RATE  = 3'd1,
        REG_BIND_RATE   = 3'd2,
        REG_UNBIND_1    = 3'd3,
        REG_UNBIND_2    = 3'd4,
        REG_DESENS_RATE = 3'd5,
        REG_RESENS_RATE = 3'd6,
        REG_REVERSAL    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [FRAC_W-1:0]        open_rate;
        logic [FRAC_W-1:0]        close_rate;
        logic [FRAC_W-1:0]        bind_rate;
        logic [FRAC_W-1:0]        unbind_first;
        logic [FRAC_W-1:0]        unbind_second;
        logic [FRAC_W-1:0]        desens_rate;
        logic [FRAC_W-1:0]        resens_rate;
        logic signed [FRAC_W-1:0] reversal;
    } cfg_t;

    typedef enum logic [3:0] {
        A_BIND, A_OPEN, A_CLOSE, A_RESENS, A_UNB1, A_UNB2, A_DESENS, A_KB, A_GAIN, A_COND
    } opa_sel_t;

    typedef enum logic [3:0] {
        B_NT, B_O, B_C0, B_C1, B_C2, B_D1, B_D2, B_OPEN_SAT, B_DIFF
    } opb_sel_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_KB, WB_O, WB_C2, WB_C1, WB_D1, WB_D2, WB_G, WB_DONE
    } wb_dst_t;

    typedef struct packed {
        logic     issue;   // start a product this cycle
        logic     first;   // product opens a new sum
        logic     neg;     // product is subtracted
        opa_sel_t a_sel;
        opb_sel_t b_sel;
        wb_dst_t  wb;      // write back the sum finished last cycle
    } ucode_t;

    // Step table. A product issued at step n is summed at n+1, so a group whose last
    // product issues at step n is written back at n+2; the next group may open at n+1.
    function automatic ucode_t ucode_at(input logic [STEP_W-1:0] step);
        ucode_t u;
        u = '{issue: 1'b0, first: 1'b0, neg: 1'b0, a_sel: A_BIND, b_sel: B_NT, wb: WB_NONE};
        unique case (step)
            5'd0:  begin u.issue = 1'b1; u.first = 1'b1; u.a_sel = A_BIND; u.b_sel = B_NT; end
            5'd1:  begin u.issue = 1'b1; u.first = 1'b1; u.a_sel = A_OPEN; u.b_sel = B_C2; end
            5'd2:  begin
                u.issue = 1'b1; u.neg = 1'b1; u.a_sel = A_CLOSE; u.b_sel = B_O; u.wb = WB_KB;
            end
            5'd3:  begin u.issue = 1'b1; u.first = 1'b1; u.a_sel = A_KB; u.b_sel = B_C1; end
            5'd4:  begin u.issue = 1'b1; u.a_sel = A_RESENS; u.b_sel = B_D2; u.wb = WB_O; end
            5'd5:  begin u.issue = 1'b1; u.a_sel = A_CLOSE; u.b_sel = B_O; end
            5'd6:  begin u.issue = 1'b1; u.neg = 1'b1; u.a_sel = A_OPEN; u.b_sel = B_C2; end
            5'd7:  begin u.issue = 1'b1; u.neg = 1'b1; u.a_sel = A_UNB2; u.b_sel = B_C2; end
            5'd8:  begin u.issue = 1'b1; u.neg = 1'b1; u.a_sel = A_DESENS; u.b_sel = B_C2; end
            5'd9:  begin u.issue = 1'b1; u.first = 1'b1; u.a_sel = A_KB; u.b_sel = B_C0; end
            5'd10: begin u.issue = 1'b1; u.a_sel = A_RESENS; u.b_sel = B_D1; u.wb = WB_C2; end
            5'd11: begin u.issue = 1'b1; u.a_sel = A_UNB2; u.b_sel = B_C2; end
            5'd12: begin u.issue = 1'b1; u.neg = 1'b1; u.a_sel = A_KB; u.b_sel = B_C1; end
            5'd13: begin u.issue = 1'b1; u.neg = 1'b1; u.a_sel = A_UNB1; u.b_sel = B_C1; end
            5'd14: begin u.issue = 1'b1; u.neg = 1'b1; u.a_sel = A_DESENS; u.b_sel = B_C1; end
            5'd15: begin u.issue = 1'b1; u.first = 1'b1; u.a_sel = A_DESENS; u.b_sel = B_C2; end
            5'd16: begin
                u.issue = 1'b1; u.neg = 1'b1; u.a_sel = A_RESENS; u.b_sel = B_D2; u.wb = WB_C1;
            end
            5'd17: begin
                u.issue = 1'b1; u.first = 1'b1; u.neg = 1'b1; u.a_sel = A_RESENS; u.b_sel = B_D1;
            end
            5'd18: begin u.issue = 1'b1; u.a_sel = A_DESENS; u.b_sel = B_C1; u.wb = WB_D2; end
            5'd19: begin u.issue = 1'b1; u.first = 1'b1; u.a_sel = A_GAIN; u.b_sel = B_OPEN_SAT; end
            5'd20: begin u.wb = WB_D1; end
            5'd21: begin u.wb = WB_G; end
            5'd22: begin u.issue = 1'b1; u.first = 1'b1; u.a_sel = A_COND; u.b_sel = B_DIFF; end
            5'd24: begin u.wb = WB_DONE; end
            default: begin end
        endcase
        return u;
    endfunction

    function automatic logic [FRAC_W-1:0] clamp_frac(input logic signed [WORK_W-1:0] x);
        logic [FRAC_W-1:0] r;
        if (x[WORK_W-1]) begin
            r = '0;
        end
        else if (x > ONE_WORK) begin
            r = ONE_Q15;
        end
        else begin
            r = x[FRAC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/ampa_mks_cfg_regs.sv -----
// Configuration register file for the AMPA kinetic step block.
`timescale 1ns / 1ps

module ampa_mks_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [ampa_mks_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [ampa_mks_pkg::FRAC_W-1:0]      wr_data,
    output ampa_mks_pkg::cfg_t                   cfg
);

    ampa_mks_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (ampa_mks_pkg::cfg_index_t'(wr_index))
                ampa_mks_pkg::REG_OPEN_RATE:   cfg_reg.open_rate     <= wr_data;
                ampa_mks_pkg::REG_CLOSE_RATE:  cfg_reg.close_rate    <= wr_data;
                ampa_mks_pkg::REG_BIND_RATE:   cfg_reg.bind_rate     <= wr_data;
                ampa_mks_pkg::REG_UNBIND_1:    cfg_reg.unbind_first  <= wr_data;
                ampa_mks_pkg::REG_UNBIND_2:    cfg_reg.unbind_second <= wr_data;
                ampa_mks_pkg::REG_DESENS_RATE: cfg_reg.desens_rate   <= wr_data;
                ampa_mks_pkg::REG_RESENS_RATE: cfg_reg.resens_rate   <= wr_data;
                ampa_mks_pkg::REG_REVERSAL:    cfg_reg.reversal      <= $signed(wr_data);
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/ampa_mks_seq.sv -----
// Step sequencer that drives the shared multiply-accumulate datapath.
`timescale 1ns / 1ps

module ampa_mks_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   out_free,
    output logic                   idle,
    output logic                   done,
    output ampa_mks_pkg::ucode_t   ctl
);

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t                            state_reg, state_next;
    logic [ampa_mks_pkg::STEP_W-1:0]   step_reg, step_next;
    ampa_mks_pkg::ucode_t              uc;
    logic                              last;
    logic                              fire;

    always_comb
    begin
        uc   = ampa_mks_pkg::ucode_at(step_reg);
        last = (step_reg == ampa_mks_pkg::LAST_STEP);
        // The final step waits until the output register can take the result.
        fire = (state_reg == S_RUN) && !(last && !out_free);
        ctl  = fire ? uc : '0;
        done = fire && last;
        idle = (state_reg == S_IDLE);

        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    step_next  = '0;
                end
            end
            S_RUN:
            begin
                if (fire)
                begin
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- sv/ampa_mks_datapath.sv -----
// Shared multiplier, accumulator, working fractions and kinetic state.
`timescale 1ns / 1ps

module ampa_mks_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [ampa_mks_pkg::FRAC_W-1:0]        transmitter_level,
    input  logic signed [ampa_mks_pkg::FRAC_W-1:0] post_voltage,
    input  logic [ampa_mks_pkg::FRAC_W-1:0]        conductance_gain,
    input  ampa_mks_pkg::cfg_t                     cfg,
    input  ampa_mks_pkg::ucode_t                   ctl,
    output logic [ampa_mks_pkg::FRAC_W-1:0]        open_fraction,
    output logic [ampa_mks_pkg::FRAC_W-1:0]        conductance,
    output logic signed [ampa_mks_pkg::CUR_W-1:0]  current
);

    localparam int FW = ampa_mks_pkg::FRAC_W;
    localparam int WW = ampa_mks_pkg::WORK_W;
    localparam int AW = ampa_mks_pkg::ACC_W;
    localparam int PW = ampa_mks_pkg::OPA_W + ampa_mks_pkg::OPB_W;

    // Item operands held for the whole step, and the binding rate and conductance computed during it.
    logic [FW-1:0]                          nt_reg;
    logic [FW-1:0]                          gain_reg;
    logic signed [ampa_mks_pkg::DIFF_W-1:0] diff_reg;
    logic [ampa_mks_pkg::KB_W-1:0]          kb_reg;
    logic [FW-1:0]                          g_reg;

    // Unclamped fractions as the update order produces them.
    logic signed [WW-1:0] w_o_reg, w_c2_reg, w_c1_reg, w_d1_reg, w_d2_reg;

    // Kinetic state kept between items.
    logic [FW-1:0] c0_reg, c1_reg, c2_reg, d1_reg, d2_reg, o_reg;

    // Multiply-accumulate pipeline.
    logic signed [AW-1:0] prod_reg;
    logic                 pv_reg, pfirst_reg, pneg_reg;
    logic signed [AW-1:0] acc_reg;

    logic signed [ampa_mks_pkg::OPA_W-1:0] op_a;
    logic signed [ampa_mks_pkg::OPB_W-1:0] op_b;
    logic signed [PW-1:0]                  prod_full;
    logic signed [AW-1:0]                  acc_base;
    logic signed [AW-1:0]                  acc_half;
    logic signed [AW-1:0]                  acc_kb;
    logic signed [AW-1:0]                  rnd_full;
    logic signed [WW-1:0]                  rnd;
    logic [FW-1:0]                         o_sat, c1_sat, c2_sat, d1_sat, d2_sat;
    logic [ampa_mks_pkg::SUM_W-1:0]        frac_sum;
    logic [FW-1:0]                         c0_new;

    always_comb
    begin
        unique case (ctl.a_sel)
            ampa_mks_pkg::A_BIND:   op_a = $signed({9'd0, cfg.bind_rate});
            ampa_mks_pkg::A_OPEN:   op_a = $signed({9'd0, cfg.open_rate});
            ampa_mks_pkg::A_CLOSE:  op_a = $signed({9'd0, cfg.close_rate});
            ampa_mks_pkg::A_RESENS: op_a = $signed({9'd0, cfg.resens_rate});
            ampa_mks_pkg::A_UNB1:   op_a = $signed({9'd0, cfg.unbind_first});
            ampa_mks_pkg::A_UNB2:   op_a = $signed({9'd0, cfg.unbind_second});
            ampa_mks_pkg::A_DESENS: op_a = $signed({9'd0, cfg.desens_rate});
            ampa_mks_pkg::A_KB:     op_a = $signed({1'b0, kb_reg});
            ampa_mks_pkg::A_GAIN:   op_a = $signed({9'd0, gain_reg});
            ampa_mks_pkg::A_COND:   op_a = $signed({9'd0, g_reg});
            default:                op_a = '0;
        endcase

        unique case (ctl.b_sel)
            ampa_mks_pkg::B_NT:       op_b = $signed({12'd0, nt_reg});
            ampa_mks_pkg::B_O:        op_b = w_o_reg[ampa_mks_pkg::OPB_W-1:0];
            ampa_mks_pkg::B_C0:       op_b = $signed({12'd0, c0_reg});
            ampa_mks_pkg::B_C1:       op_b = w_c1_reg[ampa_mks_pkg::OPB_W-1:0];
            ampa_mks_pkg::B_C2:       op_b = w_c2_reg[ampa_mks_pkg::OPB_W-1:0];
            ampa_mks_pkg::B_D1:       op_b = w_d1_reg[ampa_mks_pkg::OPB_W-1:0];
            ampa_mks_pkg::B_D2:       op_b = w_d2_reg[ampa_mks_pkg::OPB_W-1:0];
            ampa_mks_pkg::B_OPEN_SAT: op_b = $signed({12'd0, o_sat});
            ampa_mks_pkg::B_DIFF:     op_b = $signed({{11{diff_reg[ampa_mks_pkg::DIFF_W-1]}},
                                                      diff_reg});
            default:                  op_b = '0;
        endcase

        prod_full = op_a * op_b;
        acc_base  = pfirst_reg ? '0 : acc_reg;

        // Round half up from Q.30 to Q.15: floor(x / 2^15 + 1/2).
        acc_half = acc_reg + ampa_mks_pkg::HALF_Q15;
        rnd_full = acc_half >>> 15;
        rnd      = rnd_full[WW-1:0];
        acc_kb   = acc_reg + ampa_mks_pkg::HALF_Q8;

        o_sat  = ampa_mks_pkg::clamp_frac(w_o_reg);
        c1_sat = ampa_mks_pkg::clamp_frac(w_c1_reg);
        c2_sat = ampa_mks_pkg::clamp_frac(w_c2_reg);
        d1_sat = ampa_mks_pkg::clamp_frac(w_d1_reg);
        d2_sat = ampa_mks_pkg::clamp_frac(w_d2_reg);
        frac_sum = {2'b00, o_sat} + {2'b00, c1_sat} + {2'b00, c2_sat}
                 + {2'b00, d1_sat} + {2'b00, d2_sat};
        c0_new = (frac_sum >= ampa_mks_pkg::ONE_SUM) ? '0
                 : FW'(ampa_mks_pkg::ONE_SUM - frac_sum);

        open_fraction = o_sat;
        conductance   = g_reg;
        if (acc_reg > ampa_mks_pkg::CUR_MAX)
        begin
            current = ampa_mks_pkg::CUR_MAX[ampa_mks_pkg::CUR_W-1:0];
        end
        else if (acc_reg < ampa_mks_pkg::CUR_MIN)
        begin
            current = ampa_mks_pkg::CUR_MIN[ampa_mks_pkg::CUR_W-1:0];
        end
        else
        begin
            current = acc_reg[ampa_mks_pkg::CUR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg     <= 1'b0;
            pfirst_reg <= 1'b0;
            pneg_reg   <= 1'b0;
        end
        else
        begin
            pv_reg     <= ctl.issue;
            pfirst_reg <= ctl.first;
            pneg_reg   <= ctl.neg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[AW-1:0];
        if (pv_reg)
        begin
            acc_reg <= pneg_reg ? (acc_base - prod_reg) : (acc_base + prod_reg);
        end

        if (start)
        begin
            nt_reg   <= transmitter_level;
            gain_reg <= conductance_gain;
            diff_reg <= $signed({post_voltage[FW-1], post_voltage})
                      - $signed({cfg.reversal[FW-1], cfg.reversal});
            w_o_reg  <= $signed({14'd0, o_reg});
            w_c2_reg <= $signed({14'd0, c2_reg});
            w_c1_reg <= $signed({14'd0, c1_reg});
            w_d1_reg <= $signed({14'd0, d1_reg});
            w_d2_reg <= $signed({14'd0, d2_reg});
        end
        else
        begin
            unique case (ctl.wb)
                ampa_mks_pkg::WB_KB:   kb_reg   <= acc_kb[ampa_mks_pkg::KB_W+7:8];
                ampa_mks_pkg::WB_O:    w_o_reg  <= w_o_reg + rnd;
                ampa_mks_pkg::WB_C2:   w_c2_reg <= w_c2_reg + rnd;
                ampa_mks_pkg::WB_C1:   w_c1_reg <= w_c1_reg + rnd;
                ampa_mks_pkg::WB_D1:   w_d1_reg <= w_d1_reg + rnd;
                ampa_mks_pkg::WB_D2:   w_d2_reg <= w_d2_reg + rnd;
                ampa_mks_pkg::WB_G:    g_reg    <= rnd[FW-1:0];
                default:               begin end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= ampa_mks_pkg::ONE_Q15;
            c1_reg <= '0;
            c2_reg <= '0;
            d1_reg <= '0;
            d2_reg <= '0;
            o_reg  <= '0;
        end
        else if (ctl.wb == ampa_mks_pkg::WB_DONE)
        begin
            c0_reg <= c0_new;
            c1_reg <= c1_sat;
            c2_reg <= c2_sat;
            d1_reg <= d1_sat;
            d2_reg <= d2_sat;
            o_reg  <= o_sat;
        end
    end

endmodule

// ----- sv/ampa_markov_kinetic_step_top.sv -----
// Top level of the AMPA receptor kinetic step block: channels, sequencing, result buffer.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                Payload
//  s_axis    in         s_axis_tvalid/tready     transmitter level, voltage, gain
//  m_axis    out        m_axis_tvalid/tready     open fraction, conductance, current
//  cfg       in         cfg_valid/cfg_ready      register index and write data
//
//  An accepted item occupies the block until its final sequencer step has fired, and the
//  next item is taken only once the sequencer is idle again. The time is set by the single
//  shared multiply-accumulate unit: 21 products go through it one per cycle, and each
//  update that needs a value produced in the same step waits for its write-back.
//  Reset puts the kinetic state at all receptors closed and unbound, clears every
//  configuration register and empties the result register. A stalled output only
//  holds the final step; the next item is accepted as soon as the result is buffered.
//
//  One kinetic step runs the forward Euler updates in this order: open, double-bound
//  closed, single-bound closed, double desensitized, single desensitized. Each update
//  sees the unclamped values produced earlier in the same step. At the end every
//  fraction is clamped to [0, 1] and the unbound closed fraction takes the remainder.

module ampa_markov_kinetic_step_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // transmitter_level[15:0], post_voltage[31:16],
                                        // conductance_gain[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // open_fraction[15:0], conductance[31:16],
                                        // current[63:32]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ampa_mks_pkg::cfg_t   cfg;
    ampa_mks_pkg::ucode_t ctl;

    logic        in_xfer;
    logic        seq_idle;
    logic        seq_done;
    logic        out_free;

    logic [15:0] res_open;
    logic [15:0] res_cond;
    logic [31:0] res_cur;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;

    // Configuration writes are always taken; the register file ignores nothing since
    // every index names a register.
    assign cfg_ready = 1'b1;

    assign s_axis_tready = seq_idle;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // The result register can take a new result when empty or when it drains this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    ampa_mks_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ampa_mks_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer),
        .out_free (out_free),
        .idle     (seq_idle),
        .done     (seq_done),
        .ctl      (ctl)
    );

    ampa_mks_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (in_xfer),
        .transmitter_level (s_axis_tdata[15:0]),
        .post_voltage      ($signed(s_axis_tdata[31:16])),
        .conductance_gain  (s_axis_tdata[47:32]),
        .cfg               (cfg),
        .ctl               (ctl),
        .open_fraction     (res_open),
        .conductance       (res_cond),
        .current           (res_cur)
    );

    // Result register: loaded on the final step, cleared when the transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done)
        begin
            out_data_reg <= {res_cur, res_cond, res_open};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // No second item may enter while a step is in progress.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input accepted while a step is running");

    // A finished result never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten");

    // The reported open fraction stays within [0, 1].
    a_open_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] <= 16'h8000))
        else $error("open fraction above one");

    // A result follows only from a step that was started by an accepted item.
    a_done_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> !seq_idle)
        else $error("step finished while idle");
`endif

endmodule
